FILE: src/gsch_pkg.sv
// ----------------------------------------------------------------------------
// Graham scan convex hull package
// Item types, vector type and the orientation functions shared by the block.
// ----------------------------------------------------------------------------
package gsch_pkg;

  localparam int COORD_W = 16;
  localparam int VEC_W   = COORD_W + 1;
  localparam int CR_W    = 2 * VEC_W + 1;
  localparam int SIZE_W  = 7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } gsch_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hull_x;
    logic signed [COORD_W-1:0] hull_y;
    logic [SIZE_W-1:0]         hull_size;
    logic                      no_hull;
    logic                      overflowed;
    logic                      last_vertex;
  } gsch_out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
  } gsch_vec_t;

  typedef struct packed {
    logic clear;
    logic unload;
  } gsch_sort_ctl_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } gsch_stk_ctl_t;

  function automatic logic signed [CR_W-1:0] gsch_cross(gsch_vec_t a, gsch_vec_t b);
    logic signed [CR_W-1:0] p0;
    logic signed [CR_W-1:0] p1;
    p0 = CR_W'(a.x) * CR_W'(b.y);
    p1 = CR_W'(b.x) * CR_W'(a.y);
    return p0 - p1;
  endfunction

  function automatic logic [VEC_W-1:0] gsch_abs(logic signed [VEC_W-1:0] v);
    logic [VEC_W-1:0] r;
    r = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    return r;
  endfunction

  // Collinear vectors from the anchor lie on one ray, so the Manhattan
  // length orders them by distance.
  function automatic logic gsch_before(gsch_vec_t a, gsch_vec_t b);
    logic signed [CR_W-1:0] cr;
    logic [VEC_W:0]         da;
    logic [VEC_W:0]         db;
    cr = gsch_cross(a, b);
    da = {1'b0, gsch_abs(a.x)} + {1'b0, gsch_abs(a.y)};
    db = {1'b0, gsch_abs(b.x)} + {1'b0, gsch_abs(b.y)};
    if (cr != '0) begin
      return cr > 0;
    end
    return da < db;
  endfunction

endpackage

FILE: src/gsch_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/gsch_sort_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// Keeps the earlier of its held and incoming vector in angular order and
// passes the other on; in unload mode it takes its right neighbor's vector.
// ----------------------------------------------------------------------------
module gsch_sort_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  gsch_pkg::gsch_sort_ctl_t ctl,
  input  gsch_pkg::gsch_vec_t     in_vec,
  input  logic                    in_valid,
  input  gsch_pkg::gsch_vec_t     next_vec,
  input  logic                    next_valid,
  output gsch_pkg::gsch_vec_t     held,
  output logic                    held_valid,
  output gsch_pkg::gsch_vec_t     pass,
  output logic                    pass_valid
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctl.unload) begin
      held       <= next_vec;
      held_valid <= next_valid;
      pass_valid <= 1'b0;
    end else if (in_valid) begin
      if (!held_valid) begin
        held       <= in_vec;
        held_valid <= 1'b1;
        pass_valid <= 1'b0;
      end else if (gsch_pkg::gsch_before(in_vec, held)) begin
        held       <= in_vec;
        pass       <= held;
        pass_valid <= 1'b1;
      end else begin
        pass       <= in_vec;
        pass_valid <= 1'b1;
      end
    end else begin
      pass_valid <= 1'b0;
    end
  end

endmodule

FILE: src/gsch_stack.sv
// ----------------------------------------------------------------------------
// Hull stack
// A row of cells that shift down on push and up on pop; the top two cells
// are read at fixed places.
// ----------------------------------------------------------------------------
module gsch_stack #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gsch_pkg::gsch_stk_ctl_t    ctl,
  input  gsch_pkg::gsch_vec_t        din,
  output gsch_pkg::gsch_vec_t        top0,
  output gsch_pkg::gsch_vec_t        top1,
  output logic [$clog2(DEPTH+1)-1:0] depth
);

  gsch_pkg::gsch_vec_t cells [DEPTH];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + 1'b1;
    end else if (ctl.pop) begin
      depth <= depth - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      cells[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        cells[i] <= cells[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  assign top0 = cells[0];
  assign top1 = cells[1];

endmodule

FILE: src/graham_scan_convex_hull.sv
// ----------------------------------------------------------------------------
// Graham scan convex hull
// Points load one per cycle; the last point starts a read-back of the stored
// points into the sort cells and a sort settle. The scan follows, then the
// output of one result per cycle from the stack. busy holds off items until
// the last result, and the receiver cannot stall.
// Synchronous reset empties the block.
// ----------------------------------------------------------------------------
module graham_scan_convex_hull #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gsch_pkg::gsch_in_t  point,
  output gsch_pkg::gsch_out_t hull,
  output logic                hull_strobe
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SETW  = $clog2(MAX_POINTS + 3);
  localparam int VW    = gsch_pkg::VEC_W;
  localparam int DW    = VW + 1;
  localparam int TW    = 2 * DW + 1;
  localparam int CDW   = gsch_pkg::COORD_W;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_FEED   = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]                  state;
  logic [CW-1:0]               count;
  logic                        ovf;
  logic signed [CDW-1:0]       anc_x;
  logic signed [CDW-1:0]       anc_y;
  logic [CW-1:0]               rd_cnt;
  logic                        rd_pend;
  logic [SETW-1:0]             settle;
  gsch_pkg::gsch_vec_t         prev;
  logic                        prev_valid;
  gsch_pkg::gsch_vec_t         cand;
  logic                        cand_valid;
  logic [CW-1:0]               ncand;
  logic [CW-1:0]               size;

  logic                        accept;
  logic                        store;
  logic [2*CDW-1:0]            rd_data;
  logic signed [CDW-1:0]       rd_x;
  logic signed [CDW-1:0]       rd_y;
  gsch_pkg::gsch_vec_t         feed_vec;
  logic                        feed_valid;
  gsch_pkg::gsch_sort_ctl_t    sort_ctl;
  gsch_pkg::gsch_stk_ctl_t     stk_ctl;
  gsch_pkg::gsch_vec_t         stk_din;
  gsch_pkg::gsch_vec_t         top0;
  gsch_pkg::gsch_vec_t         top1;
  logic [CW-1:0]               depth;
  logic signed [TW-1:0]        turn;
  logic                        do_pop;
  logic                        new_dir;

  gsch_pkg::gsch_vec_t         held [MAX_POINTS];
  logic                        held_valid [MAX_POINTS];
  gsch_pkg::gsch_vec_t         pass [MAX_POINTS];
  logic                        pass_valid [MAX_POINTS];

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign store  = accept && (count < CW'(MAX_POINTS));

  gsch_ram #(
    .WIDTH (2 * CDW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[AW-1:0]),
    .wr_data ({point.point_x, point.point_y}),
    .rd_addr (rd_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_x       = rd_data[2*CDW-1:CDW];
  assign rd_y       = rd_data[CDW-1:0];
  assign feed_vec.x = VW'(rd_x) - VW'(anc_x);
  assign feed_vec.y = VW'(rd_y) - VW'(anc_y);
  assign feed_valid = rd_pend && (feed_vec != '0);

  assign sort_ctl.clear  = (state == S_LOAD);
  assign sort_ctl.unload = (state == S_SCAN) && !cand_valid && held_valid[0];

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    gsch_pkg::gsch_vec_t cin;
    logic                cin_valid;
    gsch_pkg::gsch_vec_t nxt;
    logic                nxt_valid;
    if (g == 0) begin : g_first
      assign cin       = feed_vec;
      assign cin_valid = feed_valid;
    end else begin : g_mid
      assign cin       = pass[g-1];
      assign cin_valid = pass_valid[g-1];
    end
    if (g == MAX_POINTS - 1) begin : g_end
      assign nxt       = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_inner
      assign nxt       = held[g+1];
      assign nxt_valid = held_valid[g+1];
    end
    gsch_sort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (sort_ctl),
      .in_vec     (cin),
      .in_valid   (cin_valid),
      .next_vec   (nxt),
      .next_valid (nxt_valid),
      .held       (held[g]),
      .held_valid (held_valid[g]),
      .pass       (pass[g]),
      .pass_valid (pass_valid[g])
    );
  end

  gsch_stack #(
    .DEPTH (MAX_POINTS)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stk_ctl),
    .din   (stk_din),
    .top0  (top0),
    .top1  (top1),
    .depth (depth)
  );

  always_comb begin
    logic signed [DW-1:0] bax;
    logic signed [DW-1:0] bay;
    logic signed [DW-1:0] cbx;
    logic signed [DW-1:0] cby;
    bax  = DW'(top0.x) - DW'(top1.x);
    bay  = DW'(top0.y) - DW'(top1.y);
    cbx  = DW'(cand.x) - DW'(top0.x);
    cby  = DW'(cand.y) - DW'(top0.y);
    turn = TW'(bax) * TW'(cby) - TW'(cbx) * TW'(bay);
  end

  assign do_pop  = (depth > CW'(2)) && (turn <= 0);
  assign new_dir = gsch_pkg::gsch_cross(prev, held[0]) != '0;

  always_comb begin
    stk_ctl = '0;
    stk_din = cand;
    if (state == S_SETTLE && settle == SETW'(MAX_POINTS + 2)) begin
      stk_ctl.push = 1'b1;
      stk_din      = '0;
    end else if (state == S_SCAN && cand_valid) begin
      stk_ctl.pop  = do_pop;
      stk_ctl.push = !do_pop;
    end else if (state == S_EMIT) begin
      stk_ctl.clear = (ncand < CW'(3)) || (depth == CW'(1));
      stk_ctl.pop   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      ovf         <= 1'b0;
      rd_pend     <= 1'b0;
      prev_valid  <= 1'b0;
      cand_valid  <= 1'b0;
      hull_strobe <= 1'b0;
    end else begin
      hull_strobe <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (store) begin
              count <= count + 1'b1;
              if (count == '0 || point.point_y < anc_y ||
                  (point.point_y == anc_y && point.point_x < anc_x)) begin
                anc_x <= point.point_x;
                anc_y <= point.point_y;
              end
            end else begin
              ovf <= 1'b1;
            end
            if (point.last_point) begin
              state  <= S_FEED;
              rd_cnt <= '0;
            end
          end
        end
        S_FEED: begin
          if (rd_cnt < count) begin
            rd_cnt  <= rd_cnt + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            settle  <= '0;
            state   <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          rd_pend <= 1'b0;
          settle  <= settle + 1'b1;
          if (settle == SETW'(MAX_POINTS + 2)) begin
            ncand      <= CW'(1);
            prev_valid <= 1'b0;
            cand_valid <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cand_valid) begin
            if (!do_pop) begin
              cand_valid <= 1'b0;
            end
          end else if (held_valid[0]) begin
            prev       <= held[0];
            prev_valid <= 1'b1;
            if (prev_valid && new_dir) begin
              cand       <= prev;
              cand_valid <= 1'b1;
              ncand      <= ncand + 1'b1;
            end
          end else if (prev_valid) begin
            cand       <= prev;
            cand_valid <= 1'b1;
            prev_valid <= 1'b0;
            ncand      <= ncand + 1'b1;
          end else begin
            size  <= depth;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          hull_strobe     <= 1'b1;
          hull.overflowed <= ovf;
          if (ncand < CW'(3)) begin
            hull.hull_x      <= '0;
            hull.hull_y      <= '0;
            hull.hull_size   <= '0;
            hull.no_hull     <= 1'b1;
            hull.last_vertex <= 1'b1;
          end else begin
            hull.hull_x      <= CDW'(top0.x + VW'(anc_x));
            hull.hull_y      <= CDW'(top0.y + VW'(anc_y));
            hull.hull_size   <= gsch_pkg::SIZE_W'(size);
            hull.no_hull     <= 1'b0;
            hull.last_vertex <= (depth == CW'(1));
          end
          if (ncand < CW'(3) || depth == CW'(1)) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
